FILE: design/fcba_pkg.sv
// Package with the constants and codes that the block allocator files share.
`timescale 1ns / 1ps
package fcba_pkg;
  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = 10;
  localparam int BLK_W      = 11;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int WORDS      = NUM_BLOCKS / WORD_W;
  localparam int WADDR_W    = IDX_W - BIT_W;
  localparam logic [BLK_W-1:0] NO_BLOCK = {BLK_W{1'b1}};

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE_BLOCK = 3'd1,
    OP_FREE_CHAIN = 3'd2,
    OP_WALK       = 3'd3,
    OP_EXTEND     = 3'd4
  } op_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
endpackage

FILE: design/fat_chain_block_allocator.sv
// Top level of the FAT chain block allocator with free bitmap and next table.
// After reset a clearing pass initializes both memories; no item is taken then.
// Allocate scans the 32-bit bitmap words, one word a cycle.
// Walk and extend follow one link at a time, each through a registered read of the next table.
// Free block and free chain pass through S_FC_RD and S_FC_WR for each block; one item is in work at a time.
// The result leaves through an output register, loaded from S_DONE once the output is free.
`timescale 1ns / 1ps
module fat_chain_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // op[2:0], block[13:3], depth[24:14], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], block_index[12:2], head_changed[13], zero fill
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FC_RD, S_FC_WR, S_SEEK, S_SEEK_WAIT,
    S_ALLOC_RD, S_ALLOC_CHK, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [fcba_pkg::IDX_W-1:0]   clr_q, clr_d;
  logic [2:0]                   op_q, op_d;
  logic [fcba_pkg::BLK_W-1:0]   cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic                         ext_q, ext_d;
  logic [fcba_pkg::WADDR_W-1:0] word_q, word_d;
  logic [1:0]                   rs_q, rs_d;
  logic [fcba_pkg::BLK_W-1:0]   rb_q, rb_d;
  logic                         rh_q, rh_d;
  logic                         ov_q, ov_d;
  logic [1:0]                   os_q, os_d;
  logic [fcba_pkg::BLK_W-1:0]   ob_q, ob_d;
  logic                         oh_q, oh_d;

  logic                         bm_we, nt_we;
  logic [fcba_pkg::WADDR_W-1:0] bm_waddr, bm_raddr;
  logic [fcba_pkg::WORD_W-1:0]  bm_wdata, bm_rdata;
  logic [fcba_pkg::IDX_W-1:0]   nt_waddr, nt_raddr;
  logic [fcba_pkg::BLK_W-1:0]   nt_wdata, nt_rdata;

  logic [2:0]                   in_op;
  logic [fcba_pkg::BLK_W-1:0]   in_blk, in_depth, in_head;
  logic                         in_ok;
  logic [fcba_pkg::WORD_W-1:0]  free_vec;
  logic [fcba_pkg::BIT_W-1:0]   free_bit;
  logic                         found;
  logic [fcba_pkg::BLK_W-1:0]   new_blk;

  fcba_ram #(.WIDTH(fcba_pkg::WORD_W), .DEPTH(fcba_pkg::WORDS)) u_bitmap (
    .clk_i, .we_i(bm_we), .waddr_i(bm_waddr), .wdata_i(bm_wdata),
    .raddr_i(bm_raddr), .rdata_o(bm_rdata)
  );

  fcba_ram #(.WIDTH(fcba_pkg::BLK_W), .DEPTH(fcba_pkg::NUM_BLOCKS)) u_next (
    .clk_i, .we_i(nt_we), .waddr_i(nt_waddr), .wdata_i(nt_wdata),
    .raddr_i(nt_raddr), .rdata_o(nt_rdata)
  );

  assign in_op    = s_axis_tdata[2:0];
  assign in_blk   = s_axis_tdata[13:3];
  assign in_depth = s_axis_tdata[24:14];
  assign in_ok    = !in_blk[fcba_pkg::BLK_W-1] &&
                    ({1'b0, in_blk[fcba_pkg::IDX_W-1:0]} < fcba_pkg::BLK_W'(fcba_pkg::NUM_BLOCKS));
  assign in_head  = in_ok ? in_blk : fcba_pkg::NO_BLOCK;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, oh_q, ob_q, os_q};

  always_comb begin
    free_vec = ~bm_rdata;
    free_bit = '0;
    for (int i = fcba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_bit = fcba_pkg::BIT_W'(i);
      end
    end
  end
  assign found   = |free_vec;
  assign new_blk = {1'b0, word_q, free_bit};

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    op_d    = op_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    steps_d = steps_q;
    ext_d   = ext_q;
    word_d  = word_q;
    rs_d    = rs_q;
    rb_d    = rb_q;
    rh_d    = rh_q;
    ov_d    = ov_q;
    os_d    = os_q;
    ob_d    = ob_q;
    oh_d    = oh_q;
    bm_we    = 1'b0;
    bm_waddr = cur_q[fcba_pkg::IDX_W-1:fcba_pkg::BIT_W];
    bm_wdata = bm_rdata;
    bm_raddr = cur_q[fcba_pkg::IDX_W-1:fcba_pkg::BIT_W];
    nt_we    = 1'b0;
    nt_waddr = cur_q[fcba_pkg::IDX_W-1:0];
    nt_wdata = fcba_pkg::NO_BLOCK;
    nt_raddr = cur_q[fcba_pkg::IDX_W-1:0];

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        nt_we    = 1'b1;
        nt_waddr = clr_q;
        bm_we    = (clr_q < fcba_pkg::IDX_W'(fcba_pkg::WORDS));
        bm_waddr = clr_q[fcba_pkg::WADDR_W-1:0];
        bm_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == fcba_pkg::IDX_W'(fcba_pkg::NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = in_op;
          cur_d   = in_head;
          prev_d  = fcba_pkg::NO_BLOCK;
          steps_d = (in_depth == '0) ? '0 : in_depth - 1'b1;
          ext_d   = 1'b0;
          word_d  = '0;
          rs_d    = fcba_pkg::ST_OK;
          rb_d    = fcba_pkg::NO_BLOCK;
          rh_d    = 1'b0;
          case (in_op) inside
            fcba_pkg::OP_ALLOC:      state_d = S_ALLOC_RD;
            fcba_pkg::OP_FREE_BLOCK,
            fcba_pkg::OP_FREE_CHAIN: state_d = in_ok ? S_FC_RD : S_DONE;
            fcba_pkg::OP_WALK,
            fcba_pkg::OP_EXTEND:     state_d = S_SEEK;
            default:                 state_d = S_DONE;
          endcase
        end
      end
      S_FC_RD: begin
        state_d = S_FC_WR;
      end
      S_FC_WR: begin
        bm_we = 1'b1;
        bm_wdata[cur_q[fcba_pkg::BIT_W-1:0]] = 1'b0;
        if (op_q == fcba_pkg::OP_FREE_CHAIN) begin
          nt_we = 1'b1;
          cur_d = nt_rdata;
          state_d = nt_rdata[fcba_pkg::BLK_W-1] ? S_DONE : S_FC_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SEEK: begin
        if (cur_q[fcba_pkg::BLK_W-1] || steps_q == '0) begin
          if (!cur_q[fcba_pkg::BLK_W-1]) begin
            rb_d    = cur_q;
            state_d = S_DONE;
          end else if (op_q == fcba_pkg::OP_EXTEND) begin
            ext_d   = 1'b1;
            state_d = S_ALLOC_RD;
          end else begin
            rs_d    = fcba_pkg::ST_NOT_FOUND;
            state_d = S_DONE;
          end
        end else begin
          prev_d  = cur_q;
          steps_d = steps_q - 1'b1;
          state_d = S_SEEK_WAIT;
        end
      end
      S_SEEK_WAIT: begin
        cur_d   = nt_rdata;
        state_d = S_SEEK;
      end
      S_ALLOC_RD: begin
        bm_raddr = word_q;
        state_d  = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (found) begin
          bm_we    = 1'b1;
          bm_waddr = word_q;
          bm_wdata[free_bit] = 1'b1;
          rb_d = new_blk;
          if (ext_q && !prev_q[fcba_pkg::BLK_W-1]) begin
            nt_we    = 1'b1;
            nt_waddr = prev_q[fcba_pkg::IDX_W-1:0];
            nt_wdata = new_blk;
          end
          rh_d    = ext_q && prev_q[fcba_pkg::BLK_W-1];
          state_d = S_DONE;
        end else if (word_q == fcba_pkg::WADDR_W'(fcba_pkg::WORDS - 1)) begin
          rs_d    = fcba_pkg::ST_NO_FREE;
          state_d = S_DONE;
        end else begin
          word_d   = word_q + 1'b1;
          bm_raddr = word_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          os_d    = rs_q;
          ob_d    = rb_q;
          oh_d    = rh_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      os_q    <= fcba_pkg::ST_OK;
      ob_q    <= fcba_pkg::NO_BLOCK;
      oh_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      os_q    <= os_d;
      ob_q    <= ob_d;
      oh_q    <= oh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    ext_q   <= ext_d;
    word_q  <= word_d;
    rs_q    <= rs_d;
    rb_q    <= rb_d;
    rh_q    <= rh_d;
  end
endmodule

FILE: design/fcba_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module fcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: design/fcba_checker.sv
// Port-level checker for the block allocator and its bind to the top level.
`timescale 1ns / 1ps
module fcba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result item changed while stalled.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("A second item was taken while one is in work.");

  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == fcba_pkg::ST_NO_FREE |->
      m_axis_tdata[12:2] == fcba_pkg::NO_BLOCK && !m_axis_tdata[13])
    else $error("No-free status carries a block.");

  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13] |->
      m_axis_tdata[1:0] == fcba_pkg::ST_OK && !m_axis_tdata[12])
    else $error("New head flagged without a valid block.");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("Undefined status code.");
endmodule

bind fat_chain_block_allocator fcba_checker u_fcba_checker (.*);
